@@ hdl/rbc_pkg.sv @@
// Package with shared constants, types and the sequencer state type.
`timescale 1ns / 1ps
package rbc_pkg;
    localparam int MAX_POINTS = 1024;
    localparam int ADDR_BITS  = $clog2(MAX_POINTS);
    localparam int CNT_BITS   = ADDR_BITS + 1;
    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 8;
    // Working width for fixed point coordinates and deltas.
    localparam int FIX_BITS   = COORD_BITS + FRAC_BITS + 2;
    // Width of squared sums.
    localparam int SQ_BITS    = 2 * FIX_BITS;
    localparam int RAD_BITS   = FIX_BITS;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [FIX_BITS-1:0]   fix_t;
    typedef logic [SQ_BITS-1:0]           sq_t;
    typedef logic [RAD_BITS-1:0]          rad_t;
    typedef logic [ADDR_BITS-1:0]         addr_t;

    typedef enum logic [4:0] {
        ST_LOAD, ST_P1_RD, ST_P1_RUN, ST_P1_LAST, ST_SEL_RD0, ST_SEL_RD1,
        ST_SEL_RD2, ST_SEL_RD3, ST_SEL_CMP, ST_SEED_RD0, ST_SEED_RD1,
        ST_SEED_CALC, ST_SEED_SQ, ST_SEED_SQRT, ST_P2_RD, ST_P2_WAIT,
        ST_P2_DELTA, ST_P2_SQ, ST_P2_CMP, ST_P2_SQRT, ST_P2_STEP,
        ST_P2_MUL, ST_P2_DIV, ST_P2_UPD, ST_OUT
    } state_t;

    // Start commands to the iterative arithmetic unit.
    typedef struct packed {
        logic start_sqrt;
        logic start_div;
    } arith_cmd_t;
endpackage

@@ hdl/rbc_point_ram.sv @@
// Point store: synchronous RAM with one write port, one read port and registered read data.
`timescale 1ns / 1ps
module rbc_point_ram
    import rbc_pkg::*;
(
    input  logic             clk,
    input  logic             we,
    input  addr_t            waddr,
    input  logic [2*COORD_BITS-1:0] wdata,
    input  addr_t            raddr,
    output logic [2*COORD_BITS-1:0] rdata
);
    logic [2*COORD_BITS-1:0] mem [MAX_POINTS];

    // Write and registered read.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ hdl/rbc_arith.sv @@
// Iterative square root and unsigned divide, one bit per cycle.
`timescale 1ns / 1ps
module rbc_arith
    import rbc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  arith_cmd_t cmd,
    input  sq_t        opa,
    input  sq_t        opb,
    output sq_t        result,
    output logic       busy
);
    localparam int STEP_BITS = $clog2(SQ_BITS + 1);

    logic       busy_reg, busy_next;
    logic       is_sqrt_reg, is_sqrt_next;
    logic [STEP_BITS-1:0] cnt_reg, cnt_next;
    sq_t        num_reg, num_next;
    sq_t        den_reg, den_next;
    logic [SQ_BITS:0] rem_reg, rem_next;
    sq_t        quo_reg, quo_next;
    logic [SQ_BITS+1:0] trial;

    // One restoring step per cycle for either operation.
    always_comb
    begin
        busy_next    = busy_reg;
        is_sqrt_next = is_sqrt_reg;
        cnt_next     = cnt_reg;
        num_next     = num_reg;
        den_next     = den_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        trial        = '0;
        if (cmd.start_sqrt || cmd.start_div)
        begin
            busy_next    = 1'b1;
            is_sqrt_next = cmd.start_sqrt;
            num_next     = opa;
            den_next     = opb;
            rem_next     = '0;
            quo_next     = '0;
            cnt_next     = cmd.start_sqrt ? STEP_BITS'(SQ_BITS / 2) : STEP_BITS'(SQ_BITS);
        end
        else if (busy_reg)
        begin
            if (is_sqrt_reg)
            begin
                // The partial remainder stays far below the top bits, so bit
                // SQ_BITS+1 of the difference serves as its sign.
                trial = {rem_reg[SQ_BITS-1:0], num_reg[SQ_BITS-1 -: 2]}
                        - {quo_reg[SQ_BITS-1:0], 2'b01};
                num_next = {num_reg[SQ_BITS-3:0], 2'b00};
                if (!trial[SQ_BITS+1])
                begin
                    rem_next = trial[SQ_BITS:0];
                    quo_next = {quo_reg[SQ_BITS-2:0], 1'b1};
                end
                else
                begin
                    rem_next = {rem_reg[SQ_BITS-2:0], num_reg[SQ_BITS-1 -: 2]};
                    quo_next = {quo_reg[SQ_BITS-2:0], 1'b0};
                end
            end
            else
            begin
                trial = {1'b0, rem_reg[SQ_BITS-1:0], num_reg[SQ_BITS-1]}
                        - {2'b00, den_reg};
                num_next = {num_reg[SQ_BITS-2:0], 1'b0};
                if (!trial[SQ_BITS+1])
                begin
                    rem_next = trial[SQ_BITS:0];
                    quo_next = {quo_reg[SQ_BITS-2:0], 1'b1};
                end
                else
                begin
                    rem_next = {rem_reg[SQ_BITS-1:0], num_reg[SQ_BITS-1]};
                    quo_next = {quo_reg[SQ_BITS-2:0], 1'b0};
                end
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == STEP_BITS'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    // Control and datapath registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        is_sqrt_reg <= is_sqrt_next;
        num_reg     <= num_next;
        den_reg     <= den_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
    end

    assign result = quo_reg;
    assign busy   = busy_reg;
endmodule

@@ hdl/ritter_bounding_circle_top.sv @@
// Top level: point loading, two passes over the point store and result output.
// Sequence: points are loaded into the store; after the last point, pass one finds
// the extreme points and the seed circle is formed, then pass two checks each point
// and grows the circle toward each point outside it, using the bit-serial square root
// and divider. Throughput: one point per cycle while loading, one set at a time.
// Reset: rst_n clears count, flags and sequencer; the point store is not cleared.
`timescale 1ns / 1ps
module ritter_bounding_circle_top
    import rbc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic signed [15:0]   point_x,
    input  logic signed [15:0]   point_y,
    input  logic                 last_point,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic signed [23:0]   center_x,
    output logic signed [23:0]   center_y,
    output logic [24:0]          radius_out,
    output logic                 overflow_flag
);
    state_t state_reg, state_next;
    logic [CNT_BITS-1:0] count_reg, count_next;
    logic dropped_reg, dropped_next;
    logic [CNT_BITS-1:0] idx_reg, idx_next;
    addr_t mnx_reg, mxx_reg, mny_reg, mxy_reg;
    addr_t mnx_next, mxx_next, mny_next, mxy_next;
    coord_t vmnx_reg, vmxx_reg, vmny_reg, vmxy_reg;
    coord_t vmnx_next, vmxx_next, vmny_next, vmxy_next;
    coord_t ax_reg, ay_reg, bx_reg, by_reg;
    coord_t ax_next, ay_next, bx_next, by_next;
    addr_t lo_reg, hi_reg, lo_next, hi_next;
    sq_t sqx_reg, sqx_next;
    fix_t cx_reg, cy_reg, cx_next, cy_next;
    fix_t dx_reg, dy_reg, dx_next, dy_next;
    sq_t dsq_reg, dsq_next;
    rad_t r_reg, r_next;
    rad_t dist_reg, dist_next, nr_reg, nr_next;
    sq_t prodx_reg, prody_reg, prodx_next, prody_next;
    sq_t qx_reg, qx_next;
    logic axis_reg, axis_next;
    logic [23:0] ocx_reg, ocy_reg, ocx_next, ocy_next;
    logic [24:0] orad_reg, orad_next;
    logic oflag_reg, oflag_next;

    logic ram_we;
    addr_t ram_waddr, ram_raddr;
    logic [2*COORD_BITS-1:0] ram_rdata;
    coord_t rx, ry;
    arith_cmd_t cmd;
    sq_t opa, opb, ares;
    logic abusy;
    logic in_acc;

    rbc_point_ram u_ram (
        .clk(clk), .we(ram_we), .waddr(ram_waddr),
        .wdata({point_x, point_y}), .raddr(ram_raddr), .rdata(ram_rdata));
    rbc_arith u_arith (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .opa(opa), .opb(opb),
        .result(ares), .busy(abusy));

    assign rx = ram_rdata[2*COORD_BITS-1:COORD_BITS];
    assign ry = ram_rdata[COORD_BITS-1:0];
    assign in_ready = (state_reg == ST_LOAD);
    assign in_acc = in_valid && in_ready;
    assign ram_we = in_acc && !count_reg[CNT_BITS-1];
    assign ram_waddr = count_reg[ADDR_BITS-1:0];

    function automatic fix_t to_fix(input coord_t v);
        to_fix = fix_t'(v) <<< FRAC_BITS;
    endfunction

    // Magnitude is formed at the working width and zero extended.
    function automatic logic [SQ_BITS-1:0] mag_fix(input fix_t v);
        logic [FIX_BITS-1:0] m;
        m = v[FIX_BITS-1] ? -v : v;
        mag_fix = SQ_BITS'(m);
    endfunction

    function automatic logic [23:0] clamp24(input fix_t v);
        if (v > fix_t'(24'sh7FFFFF))
            clamp24 = 24'h7FFFFF;
        else if (v < -fix_t'(25'sh800000))
            clamp24 = 24'h800000;
        else
            clamp24 = v[23:0];
    endfunction

    function automatic addr_t ram_waddr_f(input logic [CNT_BITS-1:0] i);
        ram_waddr_f = addr_t'(i - 1'b1);
    endfunction

    // Read address selection.
    always_comb
    begin
        ram_raddr = idx_reg[ADDR_BITS-1:0];
        unique case (state_reg)
            ST_SEL_RD0:  ram_raddr = mnx_reg;
            ST_SEL_RD1:  ram_raddr = mxx_reg;
            ST_SEL_RD2:  ram_raddr = mny_reg;
            ST_SEL_RD3:  ram_raddr = mxy_reg;
            ST_SEED_RD0: ram_raddr = lo_reg;
            ST_SEED_RD1: ram_raddr = hi_reg;
            default:     ram_raddr = idx_reg[ADDR_BITS-1:0];
        endcase
    end

    // Arithmetic unit commands. The seed square root takes the squared
    // distance straight from the squarer.
    always_comb
    begin
        cmd = '0;
        opa = (state_reg == ST_SEED_SQ) ? dsq_next : dsq_reg;
        opb = SQ_BITS'(dist_reg);
        if (state_reg == ST_SEED_SQ || state_reg == ST_P2_CMP)
            cmd.start_sqrt = (state_reg == ST_SEED_SQ) || (dsq_reg > sq_t'(r_reg) * sq_t'(r_reg));
        if (state_reg == ST_P2_MUL)
        begin
            cmd.start_div = 1'b1;
            opa = axis_reg ? prody_reg : prodx_reg;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:      if (in_acc && last_point) state_next = ST_P1_RD;
            ST_P1_RD:     state_next = ST_P1_RUN;
            ST_P1_RUN:    if (idx_reg == count_reg) state_next = ST_P1_LAST;
            ST_P1_LAST:   state_next = ST_SEL_RD0;
            ST_SEL_RD0:   state_next = ST_SEL_RD1;
            ST_SEL_RD1:   state_next = ST_SEL_RD2;
            ST_SEL_RD2:   state_next = ST_SEL_RD3;
            ST_SEL_RD3:   state_next = ST_SEL_CMP;
            ST_SEL_CMP:   state_next = ST_SEED_RD0;
            ST_SEED_RD0:  state_next = ST_SEED_RD1;
            ST_SEED_RD1:  state_next = ST_SEED_CALC;
            ST_SEED_CALC: state_next = ST_SEED_SQ;
            ST_SEED_SQ:   state_next = ST_SEED_SQRT;
            ST_SEED_SQRT: if (!abusy) state_next = ST_P2_RD;
            ST_P2_RD:     state_next = (idx_reg == count_reg) ? ST_OUT : ST_P2_WAIT;
            ST_P2_WAIT:   state_next = ST_P2_DELTA;
            ST_P2_DELTA:  state_next = ST_P2_SQ;
            ST_P2_SQ:     state_next = ST_P2_CMP;
            ST_P2_CMP:    state_next = (dsq_reg > sq_t'(r_reg) * sq_t'(r_reg)) ?
                                       ST_P2_SQRT : ST_P2_RD;
            ST_P2_SQRT:   if (!abusy) state_next = ST_P2_STEP;
            ST_P2_STEP:   state_next = ST_P2_MUL;
            ST_P2_MUL:    state_next = ST_P2_DIV;
            ST_P2_DIV:    if (!abusy) state_next = axis_reg ? ST_P2_UPD : ST_P2_MUL;
            ST_P2_UPD:    state_next = ST_P2_RD;
            ST_OUT:       if (out_ready) state_next = ST_LOAD;
            default:      state_next = ST_LOAD;
        endcase
    end

    // Datapath next values.
    always_comb
    begin
        count_next = count_reg; dropped_next = dropped_reg; idx_next = idx_reg;
        mnx_next = mnx_reg; mxx_next = mxx_reg; mny_next = mny_reg; mxy_next = mxy_reg;
        vmnx_next = vmnx_reg; vmxx_next = vmxx_reg; vmny_next = vmny_reg;
        vmxy_next = vmxy_reg;
        ax_next = ax_reg; ay_next = ay_reg; bx_next = bx_reg; by_next = by_reg;
        lo_next = lo_reg; hi_next = hi_reg; sqx_next = sqx_reg;
        cx_next = cx_reg; cy_next = cy_reg; dx_next = dx_reg; dy_next = dy_reg;
        dsq_next = dsq_reg; r_next = r_reg; dist_next = dist_reg; nr_next = nr_reg;
        prodx_next = prodx_reg; prody_next = prody_reg; qx_next = qx_reg;
        axis_next = axis_reg;
        ocx_next = ocx_reg; ocy_next = ocy_reg; orad_next = orad_reg;
        oflag_next = oflag_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_acc)
                begin
                    if (ram_we) count_next = count_reg + 1'b1;
                    else dropped_next = 1'b1;
                    idx_next = '0;
                end
            end
            ST_P1_RD:
            begin
                idx_next = CNT_BITS'(1);
                mnx_next = '0; mxx_next = '0; mny_next = '0; mxy_next = '0;
            end
            ST_P1_RUN:
            begin
                // Data of entry idx-1 is on the read port.
                if (idx_reg == CNT_BITS'(1))
                begin
                    vmnx_next = rx; vmxx_next = rx; vmny_next = ry; vmxy_next = ry;
                end
                else
                begin
                    if (rx < vmnx_reg) begin vmnx_next = rx; mnx_next = ram_waddr_f(idx_reg); end
                    if (rx > vmxx_reg) begin vmxx_next = rx; mxx_next = ram_waddr_f(idx_reg); end
                    if (ry < vmny_reg) begin vmny_next = ry; mny_next = ram_waddr_f(idx_reg); end
                    if (ry > vmxy_reg) begin vmxy_next = ry; mxy_next = ram_waddr_f(idx_reg); end
                end
                if (idx_reg != count_reg) idx_next = idx_reg + 1'b1;
            end
            ST_SEL_RD1: begin ax_next = rx; ay_next = ry; end
            ST_SEL_RD2:
            begin
                sqx_next = mag_fix(fix_t'(rx) - fix_t'(ax_reg)) ** 2
                         + mag_fix(fix_t'(ry) - fix_t'(ay_reg)) ** 2;
            end
            ST_SEL_RD3: begin ax_next = rx; ay_next = ry; end
            ST_SEL_CMP:
            begin
                lo_next = mnx_reg; hi_next = mxx_reg;
                if (mag_fix(fix_t'(rx) - fix_t'(ax_reg)) ** 2
                    + mag_fix(fix_t'(ry) - fix_t'(ay_reg)) ** 2 > sqx_reg)
                begin
                    lo_next = mny_reg; hi_next = mxy_reg;
                end
            end
            ST_SEED_RD1: begin ax_next = rx; ay_next = ry; end
            ST_SEED_CALC:
            begin
                bx_next = rx; by_next = ry;
                cx_next = fix_t'((fix_t'(ax_reg) + fix_t'(rx)) * fix_t'(1 << FRAC_BITS) / 2);
                cy_next = fix_t'((fix_t'(ay_reg) + fix_t'(ry)) * fix_t'(1 << FRAC_BITS) / 2);
                if (count_reg == CNT_BITS'(1))
                begin
                    cx_next = to_fix(rx); cy_next = to_fix(ry);
                end
            end
            ST_SEED_SQ:
            begin
                dsq_next = mag_fix(to_fix(bx_reg) - cx_reg) ** 2
                         + mag_fix(to_fix(by_reg) - cy_reg) ** 2;
                idx_next = '0;
            end
            ST_SEED_SQRT: if (!abusy) r_next = rad_t'(ares);
            ST_P2_DELTA:
            begin
                // Entry idx has been on the read port since the wait cycle.
                dx_next = to_fix(rx) - cx_reg;
                dy_next = to_fix(ry) - cy_reg;
                idx_next = idx_reg + 1'b1;
            end
            ST_P2_SQ: dsq_next = mag_fix(dx_reg) * mag_fix(dx_reg)
                               + mag_fix(dy_reg) * mag_fix(dy_reg);
            ST_P2_SQRT:
            begin
                if (!abusy)
                begin
                    dist_next = (ares == '0) ? rad_t'(1) : rad_t'(ares);
                    nr_next = rad_t'((SQ_BITS'(r_reg) + ((ares == '0) ? SQ_BITS'(1) : ares)) >> 1);
                end
            end
            ST_P2_STEP:
            begin
                prodx_next = mag_fix(dx_reg) * SQ_BITS'(nr_reg - r_reg);
                prody_next = mag_fix(dy_reg) * SQ_BITS'(nr_reg - r_reg);
                axis_next = 1'b0;
            end
            ST_P2_DIV:
            begin
                if (!abusy)
                begin
                    if (!axis_reg) qx_next = ares;
                    axis_next = 1'b1;
                end
            end
            ST_P2_UPD:
            begin
                cx_next = dx_reg[FIX_BITS-1] ? cx_reg - fix_t'(qx_reg) : cx_reg + fix_t'(qx_reg);
                cy_next = dy_reg[FIX_BITS-1] ? cy_reg - fix_t'(ares) : cy_reg + fix_t'(ares);
                r_next = nr_reg;
                axis_next = 1'b0;
            end
            ST_OUT:
            begin
                if (out_ready)
                begin
                    count_next = '0; dropped_next = 1'b0;
                end
            end
            default: ;
        endcase
        // Output register load on entering the result state.
        if (state_reg == ST_P2_RD && idx_reg == count_reg)
        begin
            ocx_next = clamp24(cx_reg);
            ocy_next = clamp24(cy_reg);
            orad_next = (r_reg > rad_t'(25'h1FFFFFF)) ? 25'h1FFFFFF : r_reg[24:0];
            oflag_next = dropped_reg;
        end
    end

    // Registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD; count_reg <= '0; dropped_reg <= 1'b0; idx_reg <= '0;
            axis_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next; count_reg <= count_next;
            dropped_reg <= dropped_next; idx_reg <= idx_next; axis_reg <= axis_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mnx_reg <= mnx_next; mxx_reg <= mxx_next; mny_reg <= mny_next; mxy_reg <= mxy_next;
        vmnx_reg <= vmnx_next; vmxx_reg <= vmxx_next; vmny_reg <= vmny_next;
        vmxy_reg <= vmxy_next;
        ax_reg <= ax_next; ay_reg <= ay_next; bx_reg <= bx_next; by_reg <= by_next;
        lo_reg <= lo_next; hi_reg <= hi_next; sqx_reg <= sqx_next;
        cx_reg <= cx_next; cy_reg <= cy_next; dx_reg <= dx_next; dy_reg <= dy_next;
        dsq_reg <= dsq_next; r_reg <= r_next; dist_reg <= dist_next; nr_reg <= nr_next;
        prodx_reg <= prodx_next; prody_reg <= prody_next; qx_reg <= qx_next;
        ocx_reg <= ocx_next; ocy_reg <= ocy_next; orad_reg <= orad_next;
        oflag_reg <= oflag_next;
    end

    assign out_valid = (state_reg == ST_OUT);
    assign center_x = ocx_reg;
    assign center_y = ocy_reg;
    assign radius_out = orad_reg;
    assign overflow_flag = oflag_reg;

    // Assertions.
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready) else $error("input taken while result pending");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_BITS'(MAX_POINTS)) else $error("point count out of range");
    a_last_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && last_point) |=> (state_reg == ST_P1_RD))
        else $error("final point did not start computation");
    a_out_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready) |=> (count_reg == '0 && !dropped_reg))
        else $error("set not cleared after result");
endmodule

@@ tb/sv/ritter_bounding_circle_top_tb.sv @@
// Self-checking testbench for the Ritter bounding circle block.
`timescale 1ns / 1ps
module ritter_bounding_circle_top_tb;
    import rbc_pkg::*;

    localparam int CLK_HALF   = 10;
    localparam int IDLE_LIMIT = 1000000;
    localparam int RAND_ITEMS = 1550;

    // One point of the current set, held as plain integers.
    typedef struct {
        longint x;
        longint y;
    } point_t;

    // One circle result as it appears on the output ports.
    typedef struct {
        logic signed [23:0] cx;
        logic signed [23:0] cy;
        logic [24:0]        rad;
        logic               ovf;
    } circle_t;

    // Directed stimulus row, with an optional typed-in result.
    typedef struct {
        int      x;
        int      y;
        bit      last;
        bit      typed;
        circle_t res;
    } row_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic               last_point;
    logic               out_valid;
    logic               out_ready;
    logic signed [23:0] center_x;
    logic signed [23:0] center_y;
    logic [24:0]        radius_out;
    logic               overflow_flag;

    point_t  set_points[$];
    bit      set_dropped;
    circle_t circle_q[$];
    int      err_cnt;
    int      idle_cycles;
    int      burst_left;
    int      gap_left;
    int      rd_cycle;
    int      rd_mode;
    logic [31:0] rd_mask;
    row_t    rows[$];

    ritter_bounding_circle_top DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .point_x(point_x), .point_y(point_y), .last_point(last_point),
        .out_valid(out_valid), .out_ready(out_ready),
        .center_x(center_x), .center_y(center_y),
        .radius_out(radius_out), .overflow_flag(overflow_flag)
    );

    // Clock generation.
    always
    begin
        clk = 1'b1;
        #CLK_HALF;
        clk = 1'b0;
        #CLK_HALF;
    end

    function automatic longint unsigned magnitude(longint v);
        return v < 0 ? 64'd0 - longint'(unsigned'(v)) : longint'(unsigned'(v));
    endfunction

    function automatic longint unsigned square_sum(longint a, longint b);
        longint unsigned ma;
        longint unsigned mb;
        ma = magnitude(a);
        mb = magnitude(b);
        return ma * ma + mb * mb;
    endfunction

    // Bit-by-bit integer square root, floor of the true root.
    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned root;
        longint unsigned b;
        root = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= root + b)
            begin
                v = v - (root + b);
                root = (root >> 1) + b;
            end
            else
                root = root >> 1;
            b = b >> 2;
        end
        return root;
    endfunction

    function automatic logic [23:0] clamp24(longint v);
        if (v > 64'sd8388607)
            v = 8388607;
        if (v < -64'sd8388608)
            v = -8388608;
        return v[23:0];
    endfunction

    // Computes the bounding circle of the stored set.
    function automatic circle_t fit_circle();
        longint  one;
        longint  cx;
        longint  cy;
        longint  dx;
        longint  dy;
        longint unsigned rad;
        longint unsigned dsq;
        longint unsigned dist_val;
        longint unsigned nr;
        longint unsigned stp;
        longint unsigned qx;
        longint unsigned qy;
        int      n;
        int      mnx;
        int      mxx;
        int      mny;
        int      mxy;
        int      lo;
        int      hi;
        circle_t c;
        one = longint'(1) << FRAC_BITS;
        n = set_points.size();
        c.ovf = set_dropped;
        if (n == 1)
        begin
            c.cx = clamp24(set_points[0].x * one);
            c.cy = clamp24(set_points[0].y * one);
            c.rad = '0;
            return c;
        end
        // Extreme points; ties keep the lower index.
        mnx = 0;
        mxx = 0;
        mny = 0;
        mxy = 0;
        for (int i = 1; i < n; i++)
        begin
            if (set_points[i].x < set_points[mnx].x) mnx = i;
            if (set_points[i].x > set_points[mxx].x) mxx = i;
            if (set_points[i].y < set_points[mny].y) mny = i;
            if (set_points[i].y > set_points[mxy].y) mxy = i;
        end
        lo = mnx;
        hi = mxx;
        if (square_sum(set_points[mxy].x - set_points[mny].x,
                       set_points[mxy].y - set_points[mny].y) >
            square_sum(set_points[mxx].x - set_points[mnx].x,
                       set_points[mxx].y - set_points[mnx].y))
        begin
            lo = mny;
            hi = mxy;
        end
        // Seed circle on the chosen pair.
        cx = ((set_points[lo].x + set_points[hi].x) * one) / 2;
        cy = ((set_points[lo].y + set_points[hi].y) * one) / 2;
        rad = int_sqrt(square_sum(set_points[hi].x * one - cx,
                                  set_points[hi].y * one - cy));
        // Grow toward every point that lies strictly outside.
        for (int i = 0; i < n; i++)
        begin
            dx = set_points[i].x * one - cx;
            dy = set_points[i].y * one - cy;
            dsq = square_sum(dx, dy);
            if (dsq > rad * rad)
            begin
                dist_val = int_sqrt(dsq);
                if (dist_val == 0)
                    dist_val = 1;
                nr = (rad + dist_val) >> 1;
                stp = nr - rad;
                qx = (magnitude(dx) * stp) / dist_val;
                qy = (magnitude(dy) * stp) / dist_val;
                cx = dx < 0 ? cx - longint'(qx) : cx + longint'(qx);
                cy = dy < 0 ? cy - longint'(qy) : cy + longint'(qy);
                rad = nr;
            end
        end
        c.cx = clamp24(cx);
        c.cy = clamp24(cy);
        c.rad = rad > 64'h1FFFFFF ? 25'h1FFFFFF : rad[24:0];
        return c;
    endfunction

    // Stores an accepted point and returns whether a result is due.
    function automatic bit store_point(int x, int y, bit last, output circle_t c);
        point_t p;
        p.x = x;
        p.y = y;
        if (set_points.size() < MAX_POINTS)
            set_points.push_back(p);
        else
            set_dropped = 1'b1;
        if (!last)
            return 1'b0;
        c = fit_circle();
        set_points.delete();
        set_dropped = 1'b0;
        return 1'b1;
    endfunction

    // Sends one point transaction, honoring the burst and gap pattern.
    task automatic send_point(int x, int y, bit last, bit typed, circle_t typed_res);
        circle_t c;
        @(negedge clk);
        if (gap_left > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap_left) @(negedge clk);
            gap_left = 0;
        end
        in_valid   <= 1'b1;
        point_x    <= x[15:0];
        point_y    <= y[15:0];
        last_point <= last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (store_point(x, y, last, c))
            circle_q.push_back(typed ? typed_res : c);
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 20);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
    endtask

    function automatic int rand_coord(int mode);
        case (mode)
            0: return $urandom_range(0, 65535) - 32768;
            1: return $urandom_range(0, 16) - 8;
            2: return ($urandom_range(0, 1) == 1) ? 32767 : -32768;
            default: return $urandom_range(0, 2000) - 1000;
        endcase
    endfunction

    // Receiver stall pattern, with a randomly rerolled mode and mask.
    always @(negedge clk)
    begin
        rd_cycle++;
        if (rd_cycle % 64 == 0)
        begin
            rd_mode = $urandom_range(0, 3);
            rd_mask = $urandom;
        end
        case (rd_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= rd_mask[rd_cycle % 32];
            2: out_ready <= ($urandom_range(0, 3) != 0);
            default: out_ready <= (rd_cycle % 8 < 5);
        endcase
    end

    // Result checking and watchdog.
    always @(posedge clk)
    begin
        circle_t e;
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (out_valid && out_ready)
            begin
                if (circle_q.size() == 0)
                begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("Unexpected result: cx=%0d cy=%0d r=%0d ovf=%0d",
                                 center_x, center_y, radius_out, overflow_flag);
                end
                else
                begin
                    e = circle_q.pop_front();
                    if (center_x !== e.cx || center_y !== e.cy ||
                        radius_out !== e.rad || overflow_flag !== e.ovf)
                    begin
                        err_cnt++;
                        if (err_cnt <= 10)
                            $display("Mismatch: exp %0d %0d %0d %0d, got %0d %0d %0d %0d",
                                     e.cx, e.cy, e.rad, e.ovf,
                                     center_x, center_y, radius_out, overflow_flag);
                    end
                end
            end
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    function automatic row_t make_row(int x, int y, bit last, bit typed,
                                      int cx, int cy, int rad);
        row_t r;
        r.x = x;
        r.y = y;
        r.last = last;
        r.typed = typed;
        r.res.cx = cx;
        r.res.cy = cy;
        r.res.rad = rad;
        r.res.ovf = 1'b0;
        return r;
    endfunction

    // Stimulus sequencer.
    initial
    begin
        int sent;
        int n;
        int mode;
        bit big_done;
        circle_t none;
        none = '{default: '0};
        rst_n = 1'b0;
        in_valid = 1'b0;
        point_x = '0;
        point_y = '0;
        last_point = 1'b0;
        out_ready = 1'b0;
        err_cnt = 0;
        idle_cycles = 0;
        rd_cycle = 0;
        rd_mode = 0;
        rd_mask = '1;
        burst_left = 4;
        gap_left = 0;
        set_dropped = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part: single points at the extremes, then small shaped sets.
        rows.push_back(make_row(0, 0, 1, 1, 0, 0, 0));
        rows.push_back(make_row(32767, 32767, 1, 1, 8388352, 8388352, 0));
        rows.push_back(make_row(-32768, -32768, 1, 1, -8388608, -8388608, 0));
        rows.push_back(make_row(32767, -32768, 1, 1, 8388352, -8388608, 0));
        rows.push_back(make_row(-32768, 0, 0, 0, 0, 0, 0));
        rows.push_back(make_row(32767, 0, 1, 1, -128, 0, 8388480));
        // A tall, narrow set of three points; its X and Y extremes are the same pair.
        rows.push_back(make_row(0, -100, 0, 0, 0, 0, 0));
        rows.push_back(make_row(1, 100, 0, 0, 0, 0, 0));
        rows.push_back(make_row(0, 0, 1, 0, 0, 0, 0));
        // Duplicate points, exercising ties on every extreme.
        rows.push_back(make_row(5, 5, 0, 0, 0, 0, 0));
        rows.push_back(make_row(5, 5, 0, 0, 0, 0, 0));
        rows.push_back(make_row(5, 5, 1, 0, 0, 0, 0));
        // A spread that forces the circle to grow in pass two.
        rows.push_back(make_row(-1000, 0, 0, 0, 0, 0, 0));
        rows.push_back(make_row(1000, 0, 0, 0, 0, 0, 0));
        rows.push_back(make_row(0, 900, 0, 0, 0, 0, 0));
        rows.push_back(make_row(700, -800, 0, 0, 0, 0, 0));
        rows.push_back(make_row(-32768, 32767, 0, 0, 0, 0, 0));
        rows.push_back(make_row(32767, -32768, 1, 0, 0, 0, 0));
        foreach (rows[i])
            send_point(rows[i].x, rows[i].y, rows[i].last, rows[i].typed, rows[i].res);

        // Random sets, mostly small, with one set that overfills the store.
        sent = 0;
        big_done = 1'b0;
        while (sent < RAND_ITEMS)
        begin
            mode = $urandom_range(0, 3);
            if (!big_done && sent > 300)
            begin
                n = MAX_POINTS + $urandom_range(1, 6);
                big_done = 1'b1;
            end
            else
                n = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40)
                                                : $urandom_range(1, 12);
            for (int k = 0; k < n; k++)
                send_point(rand_coord(mode), rand_coord(mode), k == n - 1, 0, none);
            sent += n;
        end
        @(negedge clk);
        in_valid <= 1'b0;
        last_point <= 1'b0;

        // Drain, then let any trailing activity settle.
        while (circle_q.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (err_cnt == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
